### sv/oaca_pkg.sv
// shared types and constants for the overhang area cost accumulator
package oaca_pkg;

  localparam int CoordW   = 32;
  localparam int NumCrd   = 9;
  localparam int DiffW    = CoordW + 1;
  localparam int CrossW   = 67;
  localparam int NormW    = 62;
  localparam int LimbW    = 32;
  localparam int OpW      = 2 * LimbW;
  localparam int AccW     = 128;
  localparam int RootW    = 63;
  localparam int RadW     = 2 * RootW;
  localparam int SqW      = 2 * NormW;
  localparam int SumW     = 48;
  localparam int AreaW    = 51;
  localparam int NtolW    = 31;
  localparam int HtolW    = 17;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 31;
  localparam int ExpW     = 8;

  localparam logic [SumW-1:0]    Max48          = {SumW{1'b1}};
  localparam logic [CfgIdxW-1:0] RegNormalTol   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegHeightTol   = 8'd1;
  localparam logic [NtolW-1:0]   NormalTolReset = 31'd1074;
  localparam logic [HtolW-1:0]   HeightTolReset = 17'd1;

  // one multiply step request for the shared unit
  typedef struct packed {
    logic       valid;
    logic       clr;
    logic       sub;
    logic [1:0] step;
  } mac_cmd_t;

  // which product block the sequencer is running
  typedef enum logic [2:0] {
    PhC0  = 3'd0,
    PhC1  = 3'd1,
    PhC2  = 3'd2,
    PhSqz = 3'd3,
    PhSum = 3'd4,
    PhTol = 3'd5,
    PhGn  = 3'd6
  } phase_e;

  typedef enum logic [8:0] {
    SIdle  = 9'b000000001,
    SDiff  = 9'b000000010,
    SMul   = 9'b000000100,
    SDrain = 9'b000001000,
    SUse   = 9'b000010000,
    SNorm  = 9'b000100000,
    SSqrt  = 9'b001000000,
    SAcc   = 9'b010000000,
    SFin   = 9'b100000000
  } state_e;

endpackage

### sv/overhang_area_cost_accumulator_unit.sv
// overhang area cost accumulator: sequencer, state and stream ports
//
// channel   | direction | payload (low bits first)             | handshake
// s_axis    | in        | ax ay az bx by bz cx cy cz, tlast    | tvalid/tready
// m_axis    | out       | total_cost, tuser = saturated        | tvalid/tready
// cfg       | in        | normal_tol (0), height_tol (1)       | cfg_we_i
//
// a triangle passes one idle and one difference state, three cross components of two
// products each on the shared multiplier, a normalising shift of one bit a cycle, and for
// a downward overhang the square root and more products on the multiplier, then the
// accumulate state when a root was taken, and the finish state.
// s_axis_tready is high only between triangles. reset clears the sum, the flag and the
// result valid. a waiting result stalls only a later last triangle, at its very end.
module overhang_area_cost_accumulator_unit
  import oaca_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // ax, ay, az, bx, by, bz, cx, cy, cz
  input  logic [287:0]          s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // total_cost
  output logic [47:0]           m_axis_tdata,
  // saturated
  output logic                  m_axis_tuser,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i
);

  state_e state_q, state_d;
  phase_e ph_q;
  logic   job_q;
  logic [1:0] step_q;

  logic [NtolW-1:0] normal_tol_q;
  logic [HtolW-1:0] height_tol_q;

  logic [NumCrd-1:0][CoordW-1:0] crd_q;
  logic                          last_q;
  logic [2:0][DiffW-1:0]         emag_q, fmag_q;
  logic [2:0]                    esgn_q, fsgn_q;
  logic [2:0][DiffW-1:0]         d_w;
  logic                          gh_q;
  logic [2:0][CrossW-1:0]        n_q;
  logic                          zneg_q;
  logic signed [ExpW-1:0]        s_q;
  logic [SqW-1:0]                sq_q;
  logic [61:0]                   tol2_q;
  logic                          gn_q;

  logic [SumW-1:0] cost_q;
  logic            ovf_q;
  logic            out_vld_q;
  logic [SumW-1:0] out_cost_q;
  logic            out_sat_q;

  mac_cmd_t        mac_cmd;
  logic [OpW-1:0]  op_a, op_b;
  logic            neg, sa, sb, last_job;
  logic [AccW-1:0] acc;
  logic [AccW-1:0] acc_neg;
  logic [CrossW-1:0] acc_mag;
  logic [CrossW-1:0] n_or;

  logic             sqrt_start, sqrt_done;
  logic [RootW-1:0] root;
  logic [RootW-1:0] l_minus_rz;
  logic [ExpW-1:0]  sh;
  logic [OpW-1:0]   root_sh;
  logic [AreaW-1:0] area;
  logic [AreaW:0]   sum_ext;
  logic [CoordW-1:0] az_mag;

  // shared arithmetic units
  oaca_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .acc_o  (acc)
  );

  oaca_isqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (acc[RadW-1:0]),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // edge differences relative to the first vertex
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_w[i] = {crd_q[3+i][CoordW-1], crd_q[3+i]} - {crd_q[i][CoordW-1], crd_q[i]};
    end
  end

  assign az_mag = crd_q[2][CoordW-1] ? (~crd_q[2] + 1'b1) : crd_q[2];

  // operand selection for the current product block
  always_comb begin
    op_a     = '0;
    op_b     = '0;
    neg      = 1'b0;
    sa       = 1'b0;
    sb       = 1'b0;
    last_job = 1'b1;
    case (ph_q)
      PhC0: begin
        if (!job_q) begin
          op_a = OpW'(emag_q[1]); sa = esgn_q[1];
          op_b = OpW'(fmag_q[2]); sb = fsgn_q[2];
        end else begin
          op_a = OpW'(emag_q[2]); sa = esgn_q[2];
          op_b = OpW'(fmag_q[1]); sb = fsgn_q[1]; neg = 1'b1;
        end
      end
      PhC1: begin
        if (!job_q) begin
          op_a = OpW'(emag_q[2]); sa = esgn_q[2];
          op_b = OpW'(fmag_q[0]); sb = fsgn_q[0];
        end else begin
          op_a = OpW'(emag_q[0]); sa = esgn_q[0];
          op_b = OpW'(fmag_q[2]); sb = fsgn_q[2]; neg = 1'b1;
        end
      end
      PhC2: begin
        if (!job_q) begin
          op_a = OpW'(emag_q[0]); sa = esgn_q[0];
          op_b = OpW'(fmag_q[1]); sb = fsgn_q[1];
        end else begin
          op_a = OpW'(emag_q[1]); sa = esgn_q[1];
          op_b = OpW'(fmag_q[0]); sb = fsgn_q[0]; neg = 1'b1;
        end
      end
      PhSqz: begin
        op_a = OpW'(n_q[2][NormW-1:0]);
        op_b = OpW'(n_q[2][NormW-1:0]);
        last_job = 1'b0;
      end
      PhSum: begin
        op_a = job_q ? OpW'(n_q[1][NormW-1:0]) : OpW'(n_q[0][NormW-1:0]);
        op_b = op_a;
      end
      PhTol: begin
        op_a = OpW'(normal_tol_q);
        op_b = OpW'(normal_tol_q);
        last_job = 1'b0;
      end
      PhGn: begin
        if (!job_q) begin
          op_a = OpW'(tol2_q);
          op_b = OpW'(root);
        end else begin
          op_a = OpW'(l_minus_rz);
          op_b = OpW'(1) << 61;
          neg  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign mac_cmd.valid = (state_q == SMul);
  assign mac_cmd.clr   = (step_q == 2'd0) && !job_q && (ph_q != PhSum);
  assign mac_cmd.sub   = sa ^ sb ^ neg;
  assign mac_cmd.step  = step_q;

  // magnitudes and helpers
  assign acc_neg    = ~acc + 1'b1;
  assign acc_mag    = acc[AccW-1] ? acc_neg[CrossW-1:0] : acc[CrossW-1:0];
  assign n_or       = n_q[0] | n_q[1] | n_q[2];
  assign l_minus_rz = root - RootW'(n_q[2][NormW-1:0]);
  assign sqrt_start = (state_q == SUse) && (ph_q == PhSum) && (acc < {3'b0, sq_q, 1'b0});

  // area from the root and the normalising exponent
  assign sh      = ExpW'(17) - ExpW'(s_q);
  assign root_sh = (sh >= ExpW'(64)) ? '0 : (OpW'(root) >> sh[5:0]);
  assign area    = root_sh[AreaW-1:0];
  assign sum_ext = {{(AreaW-SumW+1){1'b0}}, cost_q} + {1'b0, area};

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle:  if (s_axis_tvalid) state_d = SDiff;
      SDiff:  state_d = SMul;
      SMul:   if (step_q == 2'd3 && job_q == last_job) state_d = SDrain;
      SDrain: state_d = SUse;
      SUse: begin
        unique case (ph_q)
          PhC0, PhC1, PhSqz, PhTol: state_d = SMul;
          PhC2:    state_d = SNorm;
          PhSum:   state_d = sqrt_start ? SSqrt : SFin;
          PhGn:    state_d = SAcc;
          default: state_d = SFin;
        endcase
      end
      SNorm: begin
        if (n_or == '0 || !zneg_q) state_d = SFin;
        else if (n_or[CrossW-1:NormW] == '0 && n_or[NormW-1]) state_d = SMul;
      end
      SSqrt:  if (sqrt_done) state_d = SMul;
      SAcc:   state_d = SFin;
      SFin:   if (!last_q || !out_vld_q || m_axis_tready) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  assign s_axis_tready = (state_q == SIdle);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      ph_q         <= PhC0;
      job_q        <= 1'b0;
      step_q       <= '0;
      normal_tol_q <= NormalTolReset;
      height_tol_q <= HeightTolReset;
      cost_q       <= '0;
      ovf_q        <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegNormalTol: normal_tol_q <= cfg_data_i[NtolW-1:0];
          RegHeightTol: height_tol_q <= cfg_data_i[HtolW-1:0];
          default: ;
        endcase
      end
      // result valid: set by a finished last triangle, cleared when taken
      if (state_q == SFin && last_q && (!out_vld_q || m_axis_tready)) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        SDiff: begin
          ph_q   <= PhC0;
          job_q  <= 1'b0;
          step_q <= '0;
        end
        SMul: begin
          step_q <= step_q + 2'd1;
          if (step_q == 2'd3) job_q <= !job_q && !(job_q == last_job);
        end
        SUse: begin
          job_q  <= 1'b0;
          step_q <= '0;
          unique case (ph_q)
            PhC0:  ph_q <= PhC1;
            PhC1:  ph_q <= PhC2;
            PhSqz: ph_q <= PhSum;
            PhTol: ph_q <= PhGn;
            default: ;
          endcase
        end
        SNorm: ph_q <= PhSqz;
        SSqrt: ph_q <= PhTol;
        SAcc: begin
          if (!(gn_q && gh_q)) begin
            if (sum_ext > {{(AreaW-SumW+1){1'b0}}, Max48}) begin
              cost_q <= Max48;
              ovf_q  <= 1'b1;
            end else begin
              cost_q <= sum_ext[SumW-1:0];
            end
          end
        end
        SFin: begin
          if (last_q && (!out_vld_q || m_axis_tready)) begin
            cost_q    <= '0;
            ovf_q     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && s_axis_tvalid) begin
      for (int i = 0; i < NumCrd; i++) begin
        crd_q[i] <= s_axis_tdata[i*CoordW +: CoordW];
      end
      last_q <= s_axis_tlast;
    end
    if (state_q == SDiff) begin
      for (int i = 0; i < 3; i++) begin
        esgn_q[i] <= d_w[i][DiffW-1];
        emag_q[i] <= d_w[i][DiffW-1] ? (~d_w[i] + 1'b1) : d_w[i];
      end
      gh_q <= {1'b0, az_mag} < DiffW'(height_tol_q);
    end
    if (state_q == SUse) begin
      unique case (ph_q)
        PhC0:  n_q[0] <= acc_mag;
        PhC1:  n_q[1] <= acc_mag;
        PhC2: begin
          n_q[2] <= acc_mag;
          zneg_q <= acc[AccW-1];
          s_q    <= '0;
        end
        PhSqz: sq_q   <= acc[SqW-1:0];
        PhTol: tol2_q <= acc[61:0];
        PhGn:  gn_q   <= !acc[AccW-1] && (acc != '0);
        default: ;
      endcase
    end
    if (state_q == SNorm && n_or != '0) begin
      if (n_or[CrossW-1:NormW] != '0) begin
        for (int i = 0; i < 3; i++) n_q[i] <= n_q[i] >> 1;
        s_q <= s_q + 8'sd1;
      end else if (!n_or[NormW-1]) begin
        for (int i = 0; i < 3; i++) n_q[i] <= n_q[i] << 1;
        s_q <= s_q - 8'sd1;
      end
    end
    if (state_q == SFin && last_q && (!out_vld_q || m_axis_tready)) begin
      out_cost_q <= cost_q;
      out_sat_q  <= ovf_q;
    end
  end

  // third-vertex differences, taken while the first edge is formed
  logic [2:0][DiffW-1:0] f_w;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_w[i] = {crd_q[6+i][CoordW-1], crd_q[6+i]} - {crd_q[i][CoordW-1], crd_q[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SDiff) begin
      for (int i = 0; i < 3; i++) begin
        fsgn_q[i] <= f_w[i][DiffW-1];
        fmag_q[i] <= f_w[i][DiffW-1] ? (~f_w[i] + 1'b1) : f_w[i];
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_cost_q;
  assign m_axis_tuser  = out_sat_q;

  // checks
  a_ovf_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> cost_q == Max48)
    else $error("overflow flag set without a saturated sum");

  a_sat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata == Max48)
    else $error("saturated result without maximum total");

  a_norm_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SAcc) |-> (n_or[NormW-1] && n_or[CrossW-1:NormW] == '0))
    else $error("area formed from an unnormalised cross product");

  a_sqrt_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == SSqrt)
    else $error("square root finished outside its wait state");

endmodule

### sv/oaca_mac.sv
// shared 32x32 multiplier with a 128-bit signed accumulator
module oaca_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  oaca_pkg::mac_cmd_t                 cmd_i,
  input  logic [oaca_pkg::OpW-1:0]           op_a_i,
  input  logic [oaca_pkg::OpW-1:0]           op_b_i,
  output logic [oaca_pkg::AccW-1:0]          acc_o
);
  import oaca_pkg::*;

  logic [LimbW-1:0] limb_a, limb_b;
  logic [OpW-1:0]   prod_d, prod_q;
  logic [1:0]       shsel_d, shsel_q;
  logic             vld_q, clr_q, sub_q;
  logic [AccW-1:0]  addend, base, acc_d, acc_q;

  // limb selection and product
  assign limb_a  = cmd_i.step[1] ? op_a_i[OpW-1:LimbW] : op_a_i[LimbW-1:0];
  assign limb_b  = cmd_i.step[0] ? op_b_i[OpW-1:LimbW] : op_b_i[LimbW-1:0];
  assign prod_d  = OpW'(limb_a) * OpW'(limb_b);
  assign shsel_d = {1'b0, cmd_i.step[1]} + {1'b0, cmd_i.step[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    shsel_q <= shsel_d;
    clr_q   <= cmd_i.clr;
    sub_q   <= cmd_i.sub;
  end

  // align the partial product and accumulate
  always_comb begin
    case (shsel_q)
      2'd0:    addend = {64'b0, prod_q};
      2'd1:    addend = {32'b0, prod_q, 32'b0};
      2'd2:    addend = {prod_q, 64'b0};
      default: addend = '0;
    endcase
    base  = clr_q ? '0 : acc_q;
    acc_d = sub_q ? base - addend : base + addend;
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

### sv/oaca_isqrt.sv
// digit-by-digit integer square root, one root bit per cycle
module oaca_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [oaca_pkg::RadW-1:0]     rad_i,
  output logic                          done_o,
  output logic [oaca_pkg::RootW-1:0]    root_o
);
  import oaca_pkg::*;

  logic [RadW-1:0]  rad_q;
  logic [63:0]      rem_q, rem_d;
  logic [RootW-1:0] root_q;
  logic [5:0]       cnt_q;
  logic             busy_q, done_q;
  logic [65:0]      rem_sh, trial, rem_sub;
  logic             ge;

  // trial subtraction for the next root bit
  always_comb begin
    rem_sh  = {rem_q, rad_q[RadW-1:RadW-2]};
    trial   = {1'b0, root_q, 2'b01};
    ge      = rem_sh >= trial;
    rem_sub = ge ? rem_sh - trial : rem_sh;
    rem_d   = rem_sub[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(RootW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= {root_q[RootW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
